// File: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the RTL. They compile to nothing
// when NO_ASSERTIONS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_SAME_CYCLE(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`define ASSERT_NEXT_CYCLE(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define ASSERT_SAME_CYCLE(label, clk, rst, ante, cons, msg)

`define ASSERT_NEXT_CYCLE(label, clk, rst, ante, cons, msg)

`endif

`endif

// File: hdl/rss_pkg.sv
// ---------------------------------------------------------------------------
// rss_pkg
// Shared constants, command codes and control structs of the slot scheduler.
// ---------------------------------------------------------------------------
package rss_pkg;

   localparam int SLOT_COUNT = 8;
   localparam int IP_COUNT   = 8;
   localparam int IDX_W      = 3;
   localparam int CSR_IDX_W  = 8;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 112;

   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_CAP  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IP_DEMAND = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IP_LAT    = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_QUANTUM   = 8'd3;

   localparam logic [3:0] EMPTY_NIBBLE = 4'hF;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_START,
      OP_TICK,
      OP_FREE,
      OP_FIT,
      OP_FIND,
      OP_VICT,
      OP_LOAD,
      OP_AGE,
      OP_FINISH
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [IDX_W-1:0]  idx;
   } cmd_type;

   typedef struct packed {
      logic is_round;
      logic fit_found;
      logic swap_found;
      logic rsp_busy;
   } status_type;

endpackage

// File: hdl/reconfig_slot_scheduler_top.sv
// ---------------------------------------------------------------------------
// reconfig_slot_scheduler_top
// Tick-driven scheduler of IPs onto reconfigurable slots.
//
//   Channel  Direction  Beat contents
//   req      in         tdata[2:0] query_ip
//   rsp      out        tdata: slot_owner[31:0], reload_mask[39:32],
//                       completion_mask[47:40], query_executed[79:48],
//                       query_priority[111:80]; tuser: round_tick
//   csr      in         csr_index register number, csr_data value
//
// A plain tick steps through the slots one slot per cycle and then finishes.
// A round tick first frees finished slots one by one, then tries each IP in
// turn: a fit into a free slot, else a swap search, and when that search
// finds a victim the IP is swapped in; then the busy slots are aged.
// The next beat is taken once the previous tick has reached the result
// register; a stalled result only holds the tick after it in its last step.
// Reset is synchronous and needs no clearing pass.
// ---------------------------------------------------------------------------
module reconfig_slot_scheduler_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [rss_pkg::REQ_DATA_W-1:0]     req_tdata,   // [2:0] query_ip
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [31:0] slot_owner, [39:32] reload_mask, [47:40] completion_mask,
   // [79:48] query_executed, [111:80] query_priority
   output logic [rss_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                               rsp_tuser,   // [0] round_tick
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [rss_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [63:0]                        csr_data
);
   import rss_pkg::*;
   `include "assert_macros.svh"

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   rss_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   rss_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   `ASSERT_NEXT_CYCLE(a_one_tick_in_flight, clock, reset, req_tvalid && req_tready, !req_tready, "input taken while a tick is in progress")
   `ASSERT_SAME_CYCLE(a_finish_not_blocked, clock, reset, cmd.op == OP_FINISH, !(rsp_tvalid && !rsp_tready), "result overwritten while stalled")
   `ASSERT_SAME_CYCLE(a_reload_slot_owned, clock, reset, rsp_tvalid && rsp_tdata[32], rsp_tdata[3:0] != EMPTY_NIBBLE, "reloaded slot reported empty")

endmodule

// File: hdl/rss_ctrl.sv
// ---------------------------------------------------------------------------
// rss_ctrl
// Sequencer of one tick: walks slots and IPs and issues one datapath
// command per cycle, except while a stalled result holds the finish step.
// ---------------------------------------------------------------------------
module rss_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  rss_pkg::status_type status,
   output rss_pkg::cmd_type    cmd
);
   import rss_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TICK,
      ST_FREE,
      ST_FIT,
      ST_FIND,
      ST_VICT,
      ST_LOAD,
      ST_AGE,
      ST_FINISH
   } state_type;

   localparam logic [IDX_W-1:0] SLOT_LAST = IDX_W'(SLOT_COUNT - 1);
   localparam logic [IDX_W-1:0] IP_LAST   = IDX_W'(IP_COUNT - 1);

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      cmd.idx = idx_ff;
      unique case (state_ff)
         ST_IDLE:   cmd.op = req_tvalid ? OP_START : OP_NONE;
         ST_TICK:   cmd.op = OP_TICK;
         ST_FREE:   cmd.op = OP_FREE;
         ST_FIT:    cmd.op = OP_FIT;
         ST_FIND:   cmd.op = OP_FIND;
         ST_VICT:   cmd.op = OP_VICT;
         ST_LOAD:   cmd.op = OP_LOAD;
         ST_AGE:    cmd.op = OP_AGE;
         ST_FINISH: cmd.op = status.rsp_busy ? OP_NONE : OP_FINISH;
         default:   cmd.op = OP_NONE;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            idx_in = '0;
            if (req_tvalid) begin
               state_in = status.is_round ? ST_FREE : ST_TICK;
            end
         end
         ST_TICK: begin
            if (idx_ff == SLOT_LAST) begin
               state_in = ST_FINISH;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_FREE: begin
            if (idx_ff == SLOT_LAST) begin
               state_in = ST_FIT;
               idx_in   = '0;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_FIT: begin
            if (!status.fit_found) begin
               state_in = ST_FIND;
            end else if (idx_ff == IP_LAST) begin
               state_in = ST_AGE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_FIND: begin
            if (status.swap_found) begin
               state_in = ST_VICT;
            end else if (idx_ff == IP_LAST) begin
               state_in = ST_AGE;
            end else begin
               state_in = ST_FIT;
               idx_in   = idx_ff + 1'b1;
            end
         end
         ST_VICT: state_in = ST_LOAD;
         ST_LOAD: begin
            if (idx_ff == IP_LAST) begin
               state_in = ST_AGE;
            end else begin
               state_in = ST_FIT;
               idx_in   = idx_ff + 1'b1;
            end
         end
         ST_AGE: state_in = ST_FINISH;
         ST_FINISH: begin
            if (!status.rsp_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

// File: hdl/rss_dp.sv
// ---------------------------------------------------------------------------
// rss_dp
// Scheduler datapath: configuration tables, slot lanes, per-IP counters,
// placement searches and the result register.
// ---------------------------------------------------------------------------
module rss_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [rss_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  rss_pkg::cmd_type                   cmd,
   output rss_pkg::status_type                status,
   input  logic                               csr_valid,
   input  logic [rss_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [63:0]                        csr_data,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [rss_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                               rsp_tuser
);
   import rss_pkg::*;

   function automatic logic [7:0] byte_sel(input logic [63:0] tbl, input logic [2:0] i);
      return tbl[{i, 3'b000} +: 8];
   endfunction

   // Running remainder of elapsed modulo latency; a wrap of elapsed to zero
   // restarts it so that it always equals elapsed mod latency.
   function automatic logic [7:0] rem_step(input logic [31:0] elap, input logic [7:0] rem,
                                           input logic [7:0] lat);
      logic [7:0] latn;
      logic [8:0] r1;
      latn = (lat == 8'd0) ? 8'd1 : lat;
      r1   = {1'b0, rem} + 9'd1;
      if (elap == '1) begin
         return 8'd0;
      end else if (r1 >= {1'b0, latn}) begin
         return 8'd0;
      end
      return r1[7:0];
   endfunction

   logic [63:0] cap_tbl_ff, cap_tbl_in;
   logic [63:0] dem_tbl_ff, dem_tbl_in;
   logic [63:0] lat_tbl_ff, lat_tbl_in;
   logic [15:0] quantum_ff, quantum_in;
   logic [15:0] phase_ff, phase_in;

   logic             busy_ff  [SLOT_COUNT], busy_in  [SLOT_COUNT];
   logic [IDX_W-1:0] sip_ff   [SLOT_COUNT], sip_in   [SLOT_COUNT];
   logic [7:0]       slat_ff  [SLOT_COUNT], slat_in  [SLOT_COUNT];
   logic [31:0]      elap_ff  [SLOT_COUNT], elap_in  [SLOT_COUNT];
   logic [7:0]       srem_ff  [SLOT_COUNT], srem_in  [SLOT_COUNT];
   logic [31:0]      sprio_ff [SLOT_COUNT], sprio_in [SLOT_COUNT];
   logic [7:0]       sred_ff  [SLOT_COUNT], sred_in  [SLOT_COUNT];

   logic [31:0] iprio_ff [IP_COUNT], iprio_in [IP_COUNT];
   logic [31:0] iexec_ff [IP_COUNT], iexec_in [IP_COUNT];

   logic [IDX_W-1:0] q_ff, q_in;
   logic             round_ff, round_in;
   logic [7:0]       reload_ff, reload_in;
   logic [7:0]       done_ff, done_in;
   logic [IDX_W-1:0] vslot_ff, vslot_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_user_ff, rsp_user_in;

   logic [IDX_W-1:0] ip_addr;
   logic [31:0]      p_rd;
   logic [31:0]      e_rd;
   logic [7:0]       dem_k;
   logic             fit_found;
   logic [IDX_W-1:0] fit_slot;
   logic [7:0]       fit_cap;
   logic             swap_found;
   logic [IDX_W-1:0] swap_slot;
   logic [31:0]      owner;
   logic [31:0]      e1;
   logic [7:0]       r1;
   logic [16:0]      phase_p1;
   logic [15:0]      qn;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // One read port on the per-IP counters, addressed by the current step.
   always_comb begin
      case (cmd.op)
         OP_TICK, OP_FREE: ip_addr = sip_ff[cmd.idx];
         OP_VICT:          ip_addr = sip_ff[vslot_ff];
         OP_FINISH:        ip_addr = q_ff;
         default:          ip_addr = cmd.idx;
      endcase
   end

   assign p_rd  = iprio_ff[ip_addr];
   assign e_rd  = iexec_ff[ip_addr];
   assign dem_k = byte_sel(dem_tbl_ff, cmd.idx);

   // Smallest free slot that fits, lowest index on a tie.
   always_comb begin
      fit_found = 1'b0;
      fit_slot  = '0;
      fit_cap   = '0;
      for (int s = 0; s < SLOT_COUNT; s++) begin
         if (!busy_ff[s] && byte_sel(cap_tbl_ff, IDX_W'(s)) >= dem_k) begin
            if (!fit_found || fit_cap > byte_sel(cap_tbl_ff, IDX_W'(s))) begin
               fit_found = 1'b1;
               fit_slot  = IDX_W'(s);
               fit_cap   = byte_sel(cap_tbl_ff, IDX_W'(s));
            end
         end
      end
   end

   // First busy slot that fits and whose reduced priority beats the IP.
   always_comb begin
      swap_found = 1'b0;
      swap_slot  = '0;
      for (int s = 0; s < SLOT_COUNT; s++) begin
         if (!swap_found && busy_ff[s] && byte_sel(cap_tbl_ff, IDX_W'(s)) >= dem_k &&
             $signed(sprio_ff[s] - {24'd0, sred_ff[s]}) > $signed(p_rd)) begin
            swap_found = 1'b1;
            swap_slot  = IDX_W'(s);
         end
      end
   end

   always_comb begin
      for (int s = 0; s < 8; s++) begin
         if (s < SLOT_COUNT && busy_ff[s]) begin
            owner[s*4 +: 4] = 4'(sip_ff[s]);
         end else begin
            owner[s*4 +: 4] = EMPTY_NIBBLE;
         end
      end
   end

   assign status.is_round   = (phase_ff == 16'd0);
   assign status.fit_found  = fit_found;
   assign status.swap_found = swap_found;
   assign status.rsp_busy   = rsp_valid_ff && !rsp_tready;

   assign qn       = (quantum_ff == 16'd0) ? 16'd1 : quantum_ff;
   assign phase_p1 = {1'b0, phase_ff} + 17'd1;
   assign e1       = elap_ff[cmd.idx] + 32'd1;
   assign r1       = rem_step(elap_ff[cmd.idx], srem_ff[cmd.idx], slat_ff[cmd.idx]);

   always_comb begin
      cap_tbl_in   = cap_tbl_ff;
      dem_tbl_in   = dem_tbl_ff;
      lat_tbl_in   = lat_tbl_ff;
      quantum_in   = quantum_ff;
      phase_in     = phase_ff;
      busy_in      = busy_ff;
      sip_in       = sip_ff;
      slat_in      = slat_ff;
      elap_in      = elap_ff;
      srem_in      = srem_ff;
      sprio_in     = sprio_ff;
      sred_in      = sred_ff;
      iprio_in     = iprio_ff;
      iexec_in     = iexec_ff;
      q_in         = q_ff;
      round_in     = round_ff;
      reload_in    = reload_ff;
      done_in      = done_ff;
      vslot_in     = vslot_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_SLOT_CAP:  cap_tbl_in = csr_data;
            CSR_IP_DEMAND: dem_tbl_in = csr_data;
            CSR_IP_LAT:    lat_tbl_in = csr_data;
            CSR_QUANTUM:   quantum_in = csr_data[15:0];
            default:       ;
         endcase
      end

      case (cmd.op)
         OP_START: begin
            q_in      = req_tdata[IDX_W-1:0];
            round_in  = (phase_ff == 16'd0);
            reload_in = '0;
            done_in   = '0;
         end
         OP_TICK: begin
            if (busy_ff[cmd.idx]) begin
               elap_in[cmd.idx] = e1;
               srem_in[cmd.idx] = r1;
               if (e1 != 32'd0 && r1 == 8'd0) begin
                  sprio_in[cmd.idx] = sprio_ff[cmd.idx] + {24'd0, sred_ff[cmd.idx]};
                  iprio_in[ip_addr] = p_rd + {24'd0, sred_ff[cmd.idx]};
                  iexec_in[ip_addr] = e_rd + 32'd1;
                  done_in[ip_addr]  = 1'b1;
               end
            end
         end
         OP_FREE: begin
            if (busy_ff[cmd.idx] && elap_ff[cmd.idx] != 32'd0 && srem_ff[cmd.idx] == 8'd0) begin
               iexec_in[ip_addr] = e_rd + 32'd1;
               done_in[ip_addr]  = 1'b1;
               busy_in[cmd.idx]  = 1'b0;
            end
         end
         OP_FIT: begin
            if (fit_found) begin
               iprio_in[cmd.idx]  = p_rd + {24'd0, dem_k};
               busy_in[fit_slot]  = 1'b1;
               sip_in[fit_slot]   = cmd.idx;
               slat_in[fit_slot]  = byte_sel(lat_tbl_ff, cmd.idx);
               elap_in[fit_slot]  = '0;
               srem_in[fit_slot]  = '0;
               sprio_in[fit_slot] = p_rd + {24'd0, dem_k};
               sred_in[fit_slot]  = dem_k;
               reload_in[fit_slot] = 1'b1;
            end
         end
         OP_FIND: vslot_in = swap_slot;
         OP_VICT: iprio_in[ip_addr] = p_rd - {24'd0, sred_ff[vslot_ff]};
         OP_LOAD: begin
            // The victim's charge is already taken back, even when it is this IP.
            iprio_in[cmd.idx]  = p_rd + {24'd0, dem_k};
            busy_in[vslot_ff]  = 1'b1;
            sip_in[vslot_ff]   = cmd.idx;
            slat_in[vslot_ff]  = byte_sel(lat_tbl_ff, cmd.idx);
            elap_in[vslot_ff]  = '0;
            srem_in[vslot_ff]  = '0;
            sprio_in[vslot_ff] = p_rd;
            sred_in[vslot_ff]  = dem_k;
            reload_in[vslot_ff] = 1'b1;
         end
         OP_AGE: begin
            for (int s = 0; s < SLOT_COUNT; s++) begin
               if (busy_ff[s]) begin
                  elap_in[s] = elap_ff[s] + 32'd1;
                  srem_in[s] = rem_step(elap_ff[s], srem_ff[s], slat_ff[s]);
               end
            end
         end
         OP_FINISH: begin
            phase_in     = (phase_p1 >= {1'b0, qn}) ? 16'd0 : phase_p1[15:0];
            rsp_valid_in = 1'b1;
            rsp_user_in  = round_ff;
            rsp_data_in[31:0]  = owner;
            rsp_data_in[39:32] = reload_ff;
            rsp_data_in[47:40] = done_ff;
            if ({1'b0, q_ff} < 4'(IP_COUNT)) begin
               rsp_data_in[79:48]  = e_rd;
               rsp_data_in[111:80] = p_rd;
            end else begin
               rsp_data_in[79:48]  = '0;
               rsp_data_in[111:80] = '0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_tbl_ff   <= '0;
         dem_tbl_ff   <= '0;
         lat_tbl_ff   <= '0;
         quantum_ff   <= 16'd1;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int s = 0; s < SLOT_COUNT; s++) begin
            busy_ff[s] <= 1'b0;
         end
         for (int i = 0; i < IP_COUNT; i++) begin
            iprio_ff[i] <= '0;
            iexec_ff[i] <= '0;
         end
      end else begin
         cap_tbl_ff   <= cap_tbl_in;
         dem_tbl_ff   <= dem_tbl_in;
         lat_tbl_ff   <= lat_tbl_in;
         quantum_ff   <= quantum_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
         busy_ff      <= busy_in;
         iprio_ff     <= iprio_in;
         iexec_ff     <= iexec_in;
      end
   end

   always_ff @(posedge clock) begin
      sip_ff      <= sip_in;
      slat_ff     <= slat_in;
      elap_ff     <= elap_in;
      srem_ff     <= srem_in;
      sprio_ff    <= sprio_in;
      sred_ff     <= sred_in;
      q_ff        <= q_in;
      round_ff    <= round_in;
      reload_ff   <= reload_in;
      done_ff     <= done_in;
      vslot_ff    <= vslot_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

endmodule
